// ===== sv/pwlcs_pkg.sv =====
// Shared types and constants for the piecewise linear curve scaler.
package pwlcs_pkg;
	localparam int MAX_POINTS = 64;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_CURVE = 2'd1,
		ST_FULL     = 2'd2,
		ST_ORDER    = 2'd3
	} status_t;

	// Classified command handed from front to back.
	typedef struct packed {
		action_t     action;
		logic [15:0] point_accuracy;
		logic [15:0] point_ratio;
		logic [15:0] query_accuracy;
		logic [21:0] max_pp;
	} cmd_t;
endpackage

// ===== sv/piecewise_linear_curve_scaler_unit.sv =====
// Clear, unused code, full table and empty query go straight to the result; first point and
// out-of-order point read or write the table first; other appends run the 35-step divider.
// Queries clamp high on the last point, clamp low at entry 0, else scan the table serially
// through its read port, one breakpoint at a time for up to 64 points, then multiply and scale.
// One item is worked at a time; the next can enter the back in the cycle after the result is taken,
// and a two-entry queue absorbs items meanwhile. Reset (arst_n low, async) empties table and queue.
module piecewise_linear_curve_scaler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] point_accuracy,
	input  logic [15:0] point_ratio,
	input  logic [15:0] query_accuracy,
	input  logic [21:0] max_pp,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] ratio,
	output logic [25:0] pp
);
	import pwlcs_pkg::*;

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;

	// Pack the item fields for the queue.
	always_comb begin
		in_cmd.action         = action_t'(action);
		in_cmd.point_accuracy = point_accuracy;
		in_cmd.point_ratio    = point_ratio;
		in_cmd.query_accuracy = query_accuracy;
		in_cmd.max_pp         = max_pp;
	end

	pwlcs_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	pwlcs_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_cmd(q_cmd), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .ratio(ratio), .pp(pp)
	);
endmodule

// ===== sv/pwlcs_front.sv =====
// Input stage and command queue of the curve scaler.
module pwlcs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pwlcs_pkg::cmd_t      in_cmd,
	output logic                 q_valid,
	input  logic                 q_ready,
	output pwlcs_pkg::cmd_t      q_cmd
);
	import pwlcs_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push, pop;

	assign in_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH)) else $error("queue overflow");
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count");
`endif
endmodule

// ===== sv/pwlcs_back.sv =====
// Sequencer that executes commands: clear, table append with divide, query with search.
module pwlcs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  pwlcs_pkg::cmd_t      q_cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [15:0]          ratio,
	output logic [25:0]          pp
);
	import pwlcs_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_PREV  = 10'b0000000010,
		S_DIV   = 10'b0000000100,
		S_WRITE = 10'b0000001000,
		S_RD    = 10'b0000010000,
		S_WAIT  = 10'b0000100000,
		S_CHK   = 10'b0001000000,
		S_MUL   = 10'b0010000000,
		S_PP    = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	logic [15:0] acc_mem [MAX_POINTS];
	logic [15:0] rat_mem [MAX_POINTS];
	logic [31:0] slp_mem [MAX_POINTS];

	state_t        state_q;
	cmd_t          cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]   rd_acc_q, rd_rat_q, nx_acc_q;
	logic [31:0]   rd_slp_q;
	logic          neg_q;
	logic [15:0]   da_q;
	logic [15:0]   rem_q;
	logic [34:0]   num_q;
	logic [34:0]   quo_q;
	logic [5:0]    bit_q;
	logic [48:0]   prod_q;
	logic [1:0]    status_q;
	logic [15:0]   ratio_q;
	logic [25:0]   pp_q;
	logic          out_valid_q;
	logic [37:0]   ppp_q;

	logic [IDX_W-1:0] last_idx, nidx;
	logic [16:0]      rem_sh;
	logic [17:0]      rsub;
	logic [31:0]      slope_sat;
	logic signed [48:0] sum;
	logic [15:0]      rsat;
	logic [37:0]      pr;

	assign last_idx = IDX_W'(count_q - 1'b1);
	assign nidx     = idx_q + 1'b1;
	assign q_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign status   = status_q;
	assign ratio    = ratio_q;
	assign pp       = pp_q;

	// One restoring divide step per cycle on the shifted ratio difference.
	assign rem_sh = {rem_q, num_q[34]};
	assign rsub   = {1'b0, rem_sh} - {2'b00, da_q};

	always_comb begin
		if (neg_q) slope_sat = (quo_q >= 35'h80000000) ? 32'h80000000 : 32'(-quo_q);
		else slope_sat = (quo_q > 35'h7fffffff) ? 32'h7fffffff : quo_q[31:0];
	end

	always_comb begin
		sum = ($signed(prod_q) + 49'sd262144) >>> 19;
		sum = sum + $signed({33'd0, rd_rat_q});
		if (sum < 0) rsat = 16'd0;
		else if (sum > 49'sd65535) rsat = 16'hffff;
		else rsat = sum[15:0];
	end

	assign pr = 38'(ppp_q + 38'd2048) >> 12;

	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			acc_mem[count_q[IDX_W-1:0]] <= cmd_q.point_accuracy;
			rat_mem[count_q[IDX_W-1:0]] <= cmd_q.point_ratio;
			if (count_q != '0) slp_mem[last_idx] <= slope_sat;
		end
		rd_acc_q <= acc_mem[idx_q];
		rd_rat_q <= rat_mem[idx_q];
		rd_slp_q <= slp_mem[idx_q];
		nx_acc_q <= acc_mem[nidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					// Hold the last point on the read port so its data is ready at accept.
					idx_q <= last_idx;
					if (q_valid && q_ready) begin
						cmd_q    <= q_cmd;
						status_q <= ST_OK;
						ratio_q  <= '0;
						pp_q     <= '0;
						unique case (q_cmd.action)
							ACT_CLEAR: begin
								count_q <= '0;
								state_q <= S_OUT;
							end
							ACT_APPEND: begin
								if (count_q == CNT_W'(MAX_POINTS)) begin
									status_q <= ST_FULL;
									state_q  <= S_OUT;
								end else if (count_q == '0) begin
									state_q <= S_WRITE;
								end else begin
									state_q <= S_PREV;
								end
							end
							ACT_QUERY: begin
								if (count_q == '0) begin
									status_q <= ST_NO_CURVE;
									state_q  <= S_OUT;
								end else begin
									state_q <= S_RD;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_PREV: begin
					// Read data of the last point is valid now.
					if (cmd_q.point_accuracy <= rd_acc_q) begin
						status_q <= ST_ORDER;
						state_q  <= S_OUT;
					end else begin
						neg_q   <= cmd_q.point_ratio < rd_rat_q;
						num_q   <= {(cmd_q.point_ratio < rd_rat_q) ?
							rd_rat_q - cmd_q.point_ratio :
							cmd_q.point_ratio - rd_rat_q, 19'd0};
						da_q    <= cmd_q.point_accuracy - rd_acc_q;
						rem_q   <= '0;
						quo_q   <= '0;
						bit_q   <= 6'd35;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!rsub[17]) begin
						rem_q <= rsub[15:0];
						quo_q <= {quo_q[33:0], 1'b1};
					end else begin
						rem_q <= rem_sh[15:0];
						quo_q <= {quo_q[33:0], 1'b0};
					end
					num_q <= {num_q[33:0], 1'b0};
					bit_q <= bit_q - 1'b1;
					if (bit_q == 6'd1) state_q <= S_WRITE;
				end
				S_WRITE: begin
					count_q <= count_q + 1'b1;
					state_q <= S_OUT;
				end
				S_RD: begin
					// Last point visible; clamp high, else restart scan at entry 0.
					if (cmd_q.query_accuracy >= rd_acc_q) begin
						ratio_q <= rd_rat_q;
						state_q <= S_PP;
					end else begin
						idx_q   <= '0;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					// Let the read port catch up with the new index.
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (idx_q == '0 && cmd_q.query_accuracy <= rd_acc_q) begin
						ratio_q <= rd_rat_q;
						state_q <= S_PP;
					end else if (CNT_W'(nidx) < count_q - 1'b1 &&
							nx_acc_q <= cmd_q.query_accuracy) begin
						idx_q   <= nidx;
						state_q <= S_WAIT;
					end else begin
						prod_q  <= 49'(signed'(rd_slp_q) *
							signed'({1'b0, cmd_q.query_accuracy - rd_acc_q}));
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					ratio_q <= rsat;
					state_q <= S_PP;
				end
				S_PP: begin
					ppp_q   <= 38'(cmd_q.max_pp) * 38'(ratio_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (cmd_q.action == ACT_QUERY && status_q == ST_OK)
						pp_q <= (pr > 38'h3ffffff) ? 26'h3ffffff : pr[25:0];
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS)) else $error("count overflow");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> state_q == S_IDLE) else $error("accept while busy");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> out_valid_q) else $error("result lost");
`endif
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the piecewise linear curve scaler unit.
`timescale 1ns / 100ps
module testbench;
	import pwlcs_pkg::*;

	typedef struct packed {
		action_t     action;
		logic [15:0] point_accuracy;
		logic [15:0] point_ratio;
		logic [15:0] query_accuracy;
		logic [21:0] max_pp;
	} curve_cmd_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] ratio;
		logic [25:0] pp;
	} curve_res_t;

	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [15:0] point_accuracy;
	logic [15:0] point_ratio;
	logic [15:0] query_accuracy;
	logic [21:0] max_pp;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [15:0] ratio;
	logic [25:0] pp;

	piecewise_linear_curve_scaler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .point_accuracy(point_accuracy), .point_ratio(point_ratio),
		.query_accuracy(query_accuracy), .max_pp(max_pp),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .ratio(ratio), .pp(pp)
	);

	// Predictor copy of the breakpoint table
	logic [15:0]        bp_acc[MAX_POINTS];
	logic [15:0]        bp_ratio[MAX_POINTS];
	logic signed [31:0] bp_slope[MAX_POINTS];
	int                 bp_count;

	curve_cmd_t pending_cmds[$];
	curve_res_t expected_results[$];
	int         mismatch_count;
	int         stall_cycles;
	bit         idle_enabled;
	bit         stimulus_done;
	bit         hold_sender;
	bit         in_fired;

	function automatic logic signed [31:0] segment_slope(int a0, int r0, int a1, int r1);
		longint unsigned da;
		longint unsigned mag;
		longint unsigned quo;
		da = longint'(a1 - a0);
		mag = (r1 < r0) ? longint'(r0 - r1) : longint'(r1 - r0);
		quo = (mag << 19) / da;
		if (r1 < r0) begin
			if (quo >= 64'd2147483648) return 32'sh80000000;
			return -$signed(quo[31:0]);
		end
		if (quo > 64'd2147483647) return 32'sh7fffffff;
		return $signed(quo[31:0]);
	endfunction

	function automatic int curve_ratio_at(int q);
		int           seg;
		longint       prod;
		longint       sum;
		if (q >= bp_acc[bp_count - 1]) return bp_ratio[bp_count - 1];
		if (q <= bp_acc[0]) return bp_ratio[0];
		seg = 0;
		while (seg + 1 < bp_count - 1 && bp_acc[seg + 1] <= q) seg++;
		prod = longint'(bp_slope[seg]) * longint'(q - int'(bp_acc[seg]));
		// round half up via arithmetic shift of biased product
		sum = ((prod + (64'sd1 << 18)) >>> 19) + longint'(bp_ratio[seg]);
		if (sum < 0) return 0;
		if (sum > 65535) return 65535;
		return int'(sum);
	endfunction

	function automatic curve_res_t curve_step(curve_cmd_t c);
		curve_res_t      r;
		longint unsigned scaled;
		r = '0;
		r.status = ST_OK;
		case (c.action)
			ACT_CLEAR: begin
				bp_count = 0;
			end
			ACT_APPEND: begin
				if (bp_count >= MAX_POINTS) begin
					r.status = ST_FULL;
				end else if (bp_count > 0 && c.point_accuracy <= bp_acc[bp_count - 1]) begin
					r.status = ST_ORDER;
				end else begin
					bp_acc[bp_count] = c.point_accuracy;
					bp_ratio[bp_count] = c.point_ratio;
					if (bp_count > 0)
						bp_slope[bp_count - 1] = segment_slope(bp_acc[bp_count - 1],
							bp_ratio[bp_count - 1], c.point_accuracy, c.point_ratio);
					bp_count++;
				end
			end
			ACT_QUERY: begin
				if (bp_count == 0) begin
					r.status = ST_NO_CURVE;
				end else begin
					r.ratio = 16'(curve_ratio_at(c.query_accuracy));
					scaled = (longint'(c.max_pp) * r.ratio + 2048) >> 12;
					r.pp = (scaled > 64'h3ffffff) ? 26'h3ffffff : scaled[25:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void queue_cmd(curve_cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Driver: advance on the falling edge, holding valid until accepted
	int gap_left;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fired) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0 && !hold_sender) begin
					curve_cmd_t c;
					c = pending_cmds.pop_front();
					in_valid <= 1'b1;
					action <= c.action;
					point_accuracy <= c.point_accuracy;
					point_ratio <= c.point_ratio;
					query_accuracy <= c.query_accuracy;
					max_pp <= c.max_pp;
					if (idle_enabled && $urandom_range(0, 9) == 0)
						gap_left <= $urandom_range(1, 19);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stalls in bursts
	int stall_left;
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (idle_enabled && $urandom_range(0, 14) == 0) begin
				stall_left <= $urandom_range(0, 18);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		if (arst_n) begin
			in_fired <= in_valid && in_ready;
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (in_valid && in_ready) begin
				curve_cmd_t c;
				c.action = action_t'(action);
				c.point_accuracy = point_accuracy;
				c.point_ratio = point_ratio;
				c.query_accuracy = query_accuracy;
				c.max_pp = max_pp;
				expected_results.insert(expected_results.size(), curve_step(c));
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result status=%0d ratio=%0d pp=%0d",
							status, ratio, pp);
				end else begin
					curve_res_t e;
					e = expected_results.pop_front();
					if (e.status !== status || e.ratio !== ratio || e.pp !== pp) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: exp status=%0d ratio=%0d pp=%0d, got %0d %0d %0d",
								e.status, e.ratio, e.pp, status, ratio, pp);
					end
				end
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic curve_cmd_t make_cmd(action_t a, int pa, int pr, int qa, int mp);
		curve_cmd_t c;
		c.action = a;
		c.point_accuracy = 16'(pa);
		c.point_ratio = 16'(pr);
		c.query_accuracy = 16'(qa);
		c.max_pp = 22'(mp);
		return c;
	endfunction

	task automatic push_random_noise();
		queue_cmd(make_cmd(action_t'($urandom_range(0, 3)), $urandom(),
			$urandom(), $urandom(), $urandom()));
	endtask

	// Clear, then build a well-formed curve of up to n ascending points, then a few queries
	task automatic push_random_curve(int n, int queries);
		int acc;
		int step;
		queue_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0));
		acc = $urandom_range(0, 2000);
		for (int k = 0; k < n; k++) begin
			queue_cmd(make_cmd(ACT_APPEND, acc,
				($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 8192),
				$urandom(), $urandom()));
			step = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 4000);
			acc = acc + step;
			if (acc > 65535) break;
		end
		for (int k = 0; k < queries; k++)
			queue_cmd(make_cmd(ACT_QUERY, $urandom(), $urandom(),
				($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 32768),
				$urandom()));
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int made;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		action = ACT_NONE;
		point_accuracy = '0;
		point_ratio = '0;
		query_accuracy = '0;
		max_pp = '0;
		gap_left = 0;
		stall_left = 0;
		bp_count = 0;
		mismatch_count = 0;
		stall_cycles = 0;
		idle_enabled = 1'b1;
		stimulus_done = 1'b0;
		hold_sender = 1'b0;
		in_fired = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty query, extremes, order and table-full rejects
		queue_cmd(make_cmd(ACT_QUERY, 0, 0, 100, 22'h3fffff));
		queue_cmd(make_cmd(ACT_NONE, 16'hffff, 16'hffff, 16'hffff, 22'h3fffff));
		queue_cmd(make_cmd(ACT_APPEND, 0, 0, 0, 0));
		queue_cmd(make_cmd(ACT_APPEND, 0, 100, 0, 0));
		queue_cmd(make_cmd(ACT_APPEND, 1, 16'hffff, 0, 0));
		queue_cmd(make_cmd(ACT_APPEND, 2, 0, 0, 0));
		queue_cmd(make_cmd(ACT_APPEND, 32768, 4096, 0, 0));
		queue_cmd(make_cmd(ACT_APPEND, 16'hffff, 16'hffff, 0, 0));
		queue_cmd(make_cmd(ACT_QUERY, 0, 0, 0, 22'h3fffff));
		queue_cmd(make_cmd(ACT_QUERY, 0, 0, 1, 22'h3fffff));
		queue_cmd(make_cmd(ACT_QUERY, 0, 0, 16384, 22'h3fffff));
		queue_cmd(make_cmd(ACT_QUERY, 0, 0, 32768, 1));
		queue_cmd(make_cmd(ACT_QUERY, 0, 0, 16'hffff, 22'h3fffff));
		queue_cmd(make_cmd(ACT_CLEAR, 0, 0, 0, 0));
		queue_cmd(make_cmd(ACT_QUERY, 0, 0, 0, 0));
		// fill the table to overflow, then query the full table
		for (int k = 0; k < MAX_POINTS; k++)
			queue_cmd(make_cmd(ACT_APPEND, k * 512, k * 1000, 0, 0));
		queue_cmd(make_cmd(ACT_APPEND, 16'hffff, 0, 0, 0));
		queue_cmd(make_cmd(ACT_QUERY, 0, 0, 32767, 22'h200000));
		queue_cmd(make_cmd(ACT_QUERY, 0, 0, 257, 22'h3fffff));

		// wait until every expected result has come, then hold off the sender
		wait_drained();
		hold_sender = 1'b1;
		repeat (3) @(posedge clk);
		hold_sender = 1'b0;

		made = 0;
		while (made < 370) begin
			int n;
			int nq;
			if ($urandom_range(0, 4) == 0) begin
				push_random_noise();
				made++;
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 8);
				nq = $urandom_range(2, 8);
				push_random_curve(n, nq);
				made += n + nq + 1;
			end
			wait_drained();
			if (made > 300) idle_enabled = 1'b0;
		end
		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
sv/pwlcs_pkg.sv
sv/pwlcs_front.sv
sv/pwlcs_back.sv
sv/piecewise_linear_curve_scaler_unit.sv
test/testbench.sv
